@@ hdl/hslrgb_pkg.sv @@
`default_nettype none

package hslrgb_pkg;

	// Width of every color field on the streams.
	localparam int FIELD_W = 16;
	// Three fields packed back to back fill six whole bytes.
	localparam int DATA_W = 3 * FIELD_W;
	// Number of color channels.
	localparam int NUM_CH = 3;

	// Piece of the hue ramp that one channel falls into.
	typedef enum logic [1:0] {
		RAMP_RISE,
		RAMP_HIGH,
		RAMP_FALL,
		RAMP_LOW
	} ramp_region_t;

endpackage

`default_nettype wire

@@ hdl/hsl_to_rgb_converter_core.sv @@
`default_nettype none

// HSL to RGB color converter, one pixel per clock while the receiver does not stall.
//
// Input words arrive on the s_ channel and results leave on the m_ channel.
// Each word carries one color as three unsigned fractions with FRAC_BITS
// fraction bits, packed into 16-bit fields of tdata. Hue is taken modulo one
// turn; saturation and lightness above one are clamped just below one.
// Each output channel is saturated at the largest value below one, or at
// 65535 when that is smaller.
//
// The datapath is a five-stage pipeline: input clamp and hue offsets, the
// saturation times lightness product, the two levels with ramp region
// selection, the three ramp products, and the final add and saturate into
// the output register. A word accepted into stage 1 raises m_tvalid once it
// reaches the output register, and a new word can be accepted in every
// cycle while the receiver does not stall.
//
// Reset clears all valid bits, so the pipeline comes up empty and ready.
// When the receiver stalls, words pile up stage by stage; s_tready drops
// only once all five stages hold a word, and nothing is lost or repeated.

module hsl_to_rgb_converter_core
	import hslrgb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	// Fields from bit 0 up: hue[15:0], saturation[31:16], lightness[47:32].
	input  wire logic [DATA_W-1:0] s_tdata,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	// Fields from bit 0 up: red[15:0], green[31:16], blue[47:32].
	output      logic [DATA_W-1:0] m_tdata
);

	localparam int F = FRAC_BITS;
	// Width that holds both a raw input field and a full fraction.
	localparam int CW = (F > FIELD_W) ? F : FIELD_W;
	localparam logic [CW-1:0] FRAC_MAX = CW'((64'd1 << F) - 64'd1);
	// A third of a turn, rounded to nearest, and its complement.
	localparam logic [F-1:0] THIRD_F = F'(((64'd1 << F) + 64'd1) / 64'd3);
	localparam logic [F-1:0] TWO_THIRD_F =
		F'((64'd1 << F) - (((64'd1 << F) + 64'd1) / 64'd3));
	localparam logic [F+2:0] ONE_X = (F+3)'(64'd1 << F);
	localparam logic [F+2:0] FOUR_ONE_X = (F+3)'(64'd4 << F);
	localparam logic [F+1:0] TWO_ONE_X = (F+2)'(64'd2 << F);
	localparam logic [F+1:0] MAX_OUT =
		(F < FIELD_W) ? (F+2)'((64'd1 << F) - 64'd1) : (F+2)'(64'd65535);

	// Stage enables: a stage loads when it is empty or its word moves on.
	logic en1, en2, en3, en4, en5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign en5 = !valid_s5 || m_tready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 1: hue wrap, clamp of saturation and lightness, hue offsets.
	logic [CW-1:0] hue_ext, sat_ext, light_ext;
	logic [CW-1:0] sat_clamp, light_clamp;
	logic [F-1:0]  hue_wrap;
	logic [F-1:0]  sat_s1, light_s1;
	logic [F-1:0]  vh_s1 [NUM_CH];

	always_comb begin
		hue_ext     = CW'(s_tdata[FIELD_W-1:0]);
		sat_ext     = CW'(s_tdata[2*FIELD_W-1:FIELD_W]);
		light_ext   = CW'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
		hue_wrap    = hue_ext[F-1:0];
		sat_clamp   = (sat_ext > FRAC_MAX) ? FRAC_MAX : sat_ext;
		light_clamp = (light_ext > FRAC_MAX) ? FRAC_MAX : light_ext;
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			sat_s1   <= sat_clamp[F-1:0];
			light_s1 <= light_clamp[F-1:0];
			vh_s1[0] <= hue_wrap + THIRD_F;
			vh_s1[1] <= hue_wrap;
			vh_s1[2] <= hue_wrap + TWO_THIRD_F;
		end
	end

	// Stage 2: product of saturation and lightness.
	logic [2*F-1:0] sl_full;
	logic [F-1:0]   prod_s2, sat_s2, light_s2;
	logic [F-1:0]   vh_s2 [NUM_CH];

	assign sl_full = (2*F)'(sat_s1) * (2*F)'(light_s1);

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			prod_s2  <= sl_full[2*F-1:F];
			sat_s2   <= sat_s1;
			light_s2 <= light_s1;
			vh_s2    <= vh_s1;
		end
	end

	// Stage 3: high and low levels, and which piece of the ramp each
	// channel falls into together with its ramp factor.
	logic [F:0]   c2_raw, c2_fix, c1_fix, d_fix;
	logic [F+1:0] c1_wide;
	logic [F+2:0] six_vh [NUM_CH];
	logic [F+2:0] fall_k [NUM_CH];
	logic [F+1:0] three_vh [NUM_CH];
	logic [F:0]   k_nxt [NUM_CH];
	ramp_region_t region_nxt [NUM_CH];

	logic [F:0]   c1_s3, c2_s3, d_s3;
	logic [F:0]   k_s3 [NUM_CH];
	ramp_region_t region_s3 [NUM_CH];

	always_comb begin
		if (!light_s2[F-1]) begin
			c2_raw = {1'b0, light_s2} + {1'b0, prod_s2};
		end else begin
			c2_raw = {1'b0, light_s2} + {1'b0, sat_s2} - {1'b0, prod_s2};
		end
		c1_wide = {1'b0, light_s2, 1'b0} - {1'b0, c2_raw};
		c1_fix  = c1_wide[F+1] ? '0 : c1_wide[F:0];
		c2_fix  = (c2_raw < c1_fix) ? c1_fix : c2_raw;
		d_fix   = c2_fix - c1_fix;
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			six_vh[i]   = ({3'b000, vh_s2[i]} << 2) + ({3'b000, vh_s2[i]} << 1);
			three_vh[i] = ({2'b00, vh_s2[i]} << 1) + {2'b00, vh_s2[i]};
			fall_k[i]   = FOUR_ONE_X - six_vh[i];
			if (six_vh[i] < ONE_X) begin
				region_nxt[i] = RAMP_RISE;
				k_nxt[i]      = six_vh[i][F:0];
			end else if (!vh_s2[i][F-1]) begin
				region_nxt[i] = RAMP_HIGH;
				k_nxt[i]      = '0;
			end else if (three_vh[i] < TWO_ONE_X) begin
				region_nxt[i] = RAMP_FALL;
				k_nxt[i]      = fall_k[i][F:0];
			end else begin
				region_nxt[i] = RAMP_LOW;
				k_nxt[i]      = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			c1_s3     <= c1_fix;
			c2_s3     <= c2_fix;
			d_s3      <= d_fix;
			k_s3      <= k_nxt;
			region_s3 <= region_nxt;
		end
	end

	// Stage 4: one ramp product per channel.
	logic [2*F+1:0] ramp_full [NUM_CH];
	logic [F:0]     term_s4 [NUM_CH];
	logic [F:0]     c1_s4, c2_s4, d_s4;
	ramp_region_t   region_s4 [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			ramp_full[i] = (2*F+2)'(d_s3) * (2*F+2)'(k_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			for (int i = 0; i < NUM_CH; i++) begin
				term_s4[i] <= ramp_full[i][2*F:F];
			end
			c1_s4     <= c1_s3;
			c2_s4     <= c2_s3;
			d_s4      <= d_s3;
			region_s4 <= region_s3;
		end
	end

	// Stage 5: pick the level for each channel, saturate, and register.
	logic [F+1:0]         level [NUM_CH];
	logic [F+1:0]         level_sat [NUM_CH];
	logic [FIELD_W-1:0]   rgb_s5 [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			unique case (region_s4[i])
				RAMP_RISE, RAMP_FALL: begin
					level[i] = {1'b0, c1_s4} + {1'b0, term_s4[i]};
				end
				RAMP_HIGH: begin
					level[i] = {1'b0, c2_s4};
				end
				RAMP_LOW: begin
					level[i] = {1'b0, c1_s4};
				end
				default: begin
					level[i] = {1'b0, c1_s4};
				end
			endcase
			level_sat[i] = (level[i] > MAX_OUT) ? MAX_OUT : level[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && valid_s4) begin
			for (int i = 0; i < NUM_CH; i++) begin
				rgb_s5[i] <= FIELD_W'(level_sat[i]);
			end
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {rgb_s5[2], rgb_s5[1], rgb_s5[0]};

	// A word held in stage 1 during a stall must still be there afterwards.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en2) |=> valid_s1)
		else $error("stage 1 word dropped during stall");

	// The low level never exceeds the high level once registered.
	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en3) |=> (c2_s3 >= c1_s3))
		else $error("low level above high level");

	// A ramp term never exceeds the level difference.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en4) |=> (term_s4[0] <= d_s4 && term_s4[1] <= d_s4 &&
			term_s4[2] <= d_s4))
		else $error("ramp term above level difference");

	// Input is refused only when every stage holds a word.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire

@@ tb/sv/tb_hsl_to_rgb_converter_core.sv @@
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter_core;
	import hslrgb_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint MAXOUT = ((ONE - 1) < 65535) ? (ONE - 1) : 65535;
	// Third of a turn, rounded to the nearest step.
	localparam longint THIRD = (ONE + 1) / 3;
	localparam int LONG_HOLD = 150;
	localparam int DRAIN_CYCLES = 20;

	// Packed so that the last field, hue, sits in the lowest bits of tdata.
	typedef struct packed {
		logic [FIELD_W-1:0] lightness;
		logic [FIELD_W-1:0] saturation;
		logic [FIELD_W-1:0] hue;
	} hsl_word_t;

	typedef struct packed {
		logic [FIELD_W-1:0] blue;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] red;
	} rgb_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;

	rgb_word_t expected_rgb_q[$];
	int        error_count = 0;
	int        burst_left = 0;
	bit        tx_idle_en = 1'b1;
	bit        rx_stall_en = 1'b1;
	bit        hold_off_req = 1'b0;

	always #5 clk = ~clk;

	hsl_to_rgb_converter_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	function automatic logic [FIELD_W-1:0] saturate_level(input longint v);
		if (v < 0) begin
			return '0;
		end
		if (v > MAXOUT) begin
			return FIELD_W'(MAXOUT);
		end
		return FIELD_W'(v);
	endfunction

	// Piecewise hue ramp between the low level c1 and the high level c2.
	function automatic longint ramp_level(input longint c1, input longint c2,
			input longint vh);
		longint       d;
		ramp_region_t region;
		d = c2 - c1;
		if (6 * vh < ONE) begin
			region = RAMP_RISE;
		end else if (2 * vh < ONE) begin
			region = RAMP_HIGH;
		end else if (3 * vh < 2 * ONE) begin
			region = RAMP_FALL;
		end else begin
			region = RAMP_LOW;
		end
		case (region)
			RAMP_RISE: return c1 + ((d * 6 * vh) >> FRAC_BITS);
			RAMP_HIGH: return c2;
			RAMP_FALL: return c1 + ((d * (4 * ONE - 6 * vh)) >> FRAC_BITS);
			default:   return c1;
		endcase
	endfunction

	function automatic rgb_word_t predict_rgb(input hsl_word_t px);
		longint    h, s, l, prod, c1, c2, hr, hb;
		rgb_word_t rgb;
		h = longint'(px.hue) & (ONE - 1);
		s = (longint'(px.saturation) > ONE - 1) ? ONE - 1 : longint'(px.saturation);
		l = (longint'(px.lightness) > ONE - 1) ? ONE - 1 : longint'(px.lightness);
		if (s == 0) begin
			// Gray: every channel is the lightness itself.
			rgb.red   = saturate_level(l);
			rgb.green = rgb.red;
			rgb.blue  = rgb.red;
			return rgb;
		end
		prod = (s * l) >> FRAC_BITS;
		c2 = (l < ONE / 2) ? (l + prod) : (l + s - prod);
		c1 = 2 * l - c2;
		if (c1 < 0) begin
			c1 = 0;
		end
		if (c2 < c1) begin
			c2 = c1;
		end
		hr = (h + THIRD) & (ONE - 1);
		hb = (h + ONE - THIRD) & (ONE - 1);
		rgb.red   = saturate_level(ramp_level(c1, c2, hr));
		rgb.green = saturate_level(ramp_level(c1, c2, h));
		rgb.blue  = saturate_level(ramp_level(c1, c2, hb));
		return rgb;
	endfunction

	// Mostly uniform, with extra weight on zero, full scale and the midpoint.
	function automatic logic [FIELD_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return FIELD_W'(32767 + $urandom_range(0, 1));
			default: return FIELD_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one word and returns once it has been accepted. In idle mode the
	// sender works in bursts with gaps between them.
	task automatic send_hsl(input hsl_word_t px);
		int gap;
		if (tx_idle_en) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 5);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic check_channel(input string name, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Expectations are queued when a word is accepted and compared in order
	// with each result word as it leaves the block.
	always @(posedge clk) begin : result_checker
		rgb_word_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_rgb_q.push_back(predict_rgb(hsl_word_t'(s_tdata)));
			end
			if (m_tvalid && m_tready) begin
				got = rgb_word_t'(m_tdata);
				if (expected_rgb_q.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got %h",
						$time, m_tdata);
					error_count++;
				end else begin
					want = expected_rgb_q.pop_front();
					check_channel("red", want.red, got.red);
					check_channel("green", want.green, got.green);
					check_channel("blue", want.blue, got.blue);
				end
			end
		end
	end

	// The receiver stalls on a random 16-bit ready pattern, drawn anew each time
	// it has been played through, and on request holds off for a long stretch of its own.
	initial begin : receiver
		logic [15:0] ready_pattern;
		int          phase;
		int          hold_left;
		ready_pattern = '1;
		phase = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_left = LONG_HOLD;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!rx_stall_en) begin
				m_tready <= 1'b1;
			end else begin
				if (phase == 0) begin
					ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
						: (16'($urandom()) | 16'h0001);
				end
				m_tready <= ready_pattern[phase];
				phase = (phase + 1) % 16;
			end
		end
	end

	// Extremes of every field, gray, full saturation with the high level
	// reaching one, and hues on both sides of each ramp boundary and wrap.
	task automatic test_directed_corners();
		hsl_word_t corners[20];
		corners[0]  = '{lightness: 16'd0,     saturation: 16'd0,     hue: 16'd0};
		corners[1]  = '{lightness: 16'd65535, saturation: 16'd0,     hue: 16'd65535};
		corners[2]  = '{lightness: 16'd32768, saturation: 16'd0,     hue: 16'd12345};
		corners[3]  = '{lightness: 16'd32768, saturation: 16'd65535, hue: 16'd0};
		corners[4]  = '{lightness: 16'd65535, saturation: 16'd65535, hue: 16'd65535};
		corners[5]  = '{lightness: 16'd32767, saturation: 16'd65535, hue: 16'd21845};
		corners[6]  = '{lightness: 16'd32768, saturation: 16'd65535, hue: 16'd43690};
		corners[7]  = '{lightness: 16'd20000, saturation: 16'd40000, hue: 16'd10922};
		corners[8]  = '{lightness: 16'd20000, saturation: 16'd40000, hue: 16'd10923};
		corners[9]  = '{lightness: 16'd50000, saturation: 16'd40000, hue: 16'd32767};
		corners[10] = '{lightness: 16'd50000, saturation: 16'd40000, hue: 16'd32768};
		corners[11] = '{lightness: 16'd30000, saturation: 16'd50000, hue: 16'd43690};
		corners[12] = '{lightness: 16'd30000, saturation: 16'd50000, hue: 16'd43691};
		corners[13] = '{lightness: 16'd1,     saturation: 16'd1,     hue: 16'd0};
		corners[14] = '{lightness: 16'd0,     saturation: 16'd65535, hue: 16'd65535};
		corners[15] = '{lightness: 16'd65535, saturation: 16'd65535, hue: 16'd21844};
		corners[16] = '{lightness: 16'd65535, saturation: 16'd30000, hue: 16'd43691};
		corners[17] = '{lightness: 16'd32768, saturation: 16'd65535, hue: 16'd54613};
		corners[18] = '{lightness: 16'd32768, saturation: 16'd32768, hue: 16'd1};
		corners[19] = '{lightness: 16'd65534, saturation: 16'd1,     hue: 16'd65535};
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;
		foreach (corners[i]) begin
			send_hsl(corners[i]);
		end
	endtask

	task automatic test_random_colors();
		hsl_word_t px;
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;
		repeat (1100) begin
			// Some hues sit close to the thirds, where the wrap of red and blue
			// and the ramp boundaries lie.
			if ($urandom_range(0, 7) == 0) begin
				px.hue = FIELD_W'(THIRD * $urandom_range(0, 2) + $urandom_range(0, 4) - 2);
			end else begin
				px.hue = FIELD_W'($urandom_range(0, 65535));
			end
			px.saturation = pick_level();
			px.lightness  = pick_level();
			send_hsl(px);
		end
	endtask

	// The receiver holds off while the sender keeps offering, so the pipeline
	// fills and the block must drop s_tready without losing a word.
	task automatic test_back_pressure();
		hsl_word_t px;
		tx_idle_en   = 1'b0;
		rx_stall_en  = 1'b1;
		hold_off_req = 1'b1;
		repeat (60) begin
			px.hue        = FIELD_W'($urandom_range(0, 65535));
			px.saturation = pick_level();
			px.lightness  = pick_level();
			send_hsl(px);
		end
	endtask

	// One word per clock in both directions with no idling at all.
	task automatic test_full_rate();
		hsl_word_t px;
		tx_idle_en  = 1'b0;
		rx_stall_en = 1'b0;
		repeat (200) begin
			px.hue        = FIELD_W'($urandom_range(0, 65535));
			px.saturation = pick_level();
			px.lightness  = pick_level();
			send_hsl(px);
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_colors();
		test_back_pressure();
		test_full_rate();
		s_tvalid <= 1'b0;
		while (expected_rgb_q.size() != 0) begin
			@(posedge clk);
		end
		// Anything the block emits after the last expected word is a failure.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
